FILE: rtl/pbss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the panel button self-test sequencer.
// No dependencies; imported by every other file of the block.
package pbss_pkg;

  localparam int TimerWidthDefault = 16;
  localparam int TickWidth         = 10;
  localparam int StepWidth         = 16;
  localparam int IdentWidth        = 12;
  localparam int NumOverrides      = 11;

  localparam logic [TickWidth-1:0] TickPeriodReset = 10'd50;
  localparam logic [StepWidth-1:0] RelayStepReset  = 16'd1000;

  localparam logic [IdentWidth-1:0] IdentMax     = 12'd4095;
  localparam logic [IdentWidth-1:0] IdentLength  = 12'd2000;
  localparam int                    HoldMedium   = 2000;
  localparam int                    HoldFast     = 4000;
  localparam int                    HoldTest     = 6000;

  localparam logic [3:0] BitBuzz = 4'd9;
  localparam logic [3:0] BitAna  = 4'd10;
  localparam logic [NumOverrides-1:0] BuzzMask = 11'b000_0010_0000 << 4;

  // blink modes
  localparam logic [2:0] BlinkOff    = 3'd0;
  localparam logic [2:0] BlinkSlow   = 3'd1;
  localparam logic [2:0] BlinkMedium = 3'd2;
  localparam logic [2:0] BlinkFast   = 3'd4;

  // configuration register indexes
  localparam logic RegTickPeriod = 1'b0;
  localparam logic RegRelayStep  = 1'b1;

  typedef struct packed {
    logic alarm_led_two_now;
    logic alarm_led_one_now;
    logic identify_request;
    logic button_two_level;
    logic button_one_level;
  } pbss_tick_t;

  typedef struct packed {
    logic [StepWidth-1:0] relay_step_ms;
    logic [TickWidth-1:0] tick_period_ms;
  } pbss_cfg_t;

  typedef struct packed {
    logic [3:0] self_test_step;
    logic [2:0] blink_speed;
    logic [2:0] analog_level_code;
    logic       analog_override_enable;
    logic       buzzer_override_level;
    logic       buzzer_override_enable;
    logic [3:0] relay_override_level;
    logic [3:0] relay_override_enable;
    logic [4:0] led_override_level;
    logic [4:0] led_override_enable;
  } pbss_result_t;

  typedef struct packed {
    logic [NumOverrides-1:0] en;
    logic [NumOverrides-1:0] lv;
  } pbss_ovr_t;

  function automatic logic [7:0] toggle_period_ms(logic [2:0] mode);
    case (mode)
      BlinkSlow:   return 8'd250;
      BlinkMedium: return 8'd125;
      BlinkFast:   return 8'd62;
      default:     return 8'd250;
    endcase
  endfunction

endpackage

FILE: rtl/pbss_apb.sv
`timescale 1ns / 1ps
// Configuration registers behind an APB-style slave port.
// Depends on pbss_pkg.
module pbss_apb
  import pbss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pbss_cfg_t   cfg_o
);

  pbss_cfg_t cfg_q, cfg_d;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        RegTickPeriod: cfg_d.tick_period_ms = pwdata[TickWidth-1:0];
        RegRelayStep:  cfg_d.relay_step_ms  = pwdata[StepWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period_ms <= TickPeriodReset;
      cfg_q.relay_step_ms  <= RelayStepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegTickPeriod: prdata = 32'(cfg_q.tick_period_ms);
      RegRelayStep:  prdata = 32'(cfg_q.relay_step_ms);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/pbss_step.sv
`timescale 1ns / 1ps
// Per-tick state update: edge detection, beep, blink, identify and self-test.
// Depends on pbss_pkg.
module pbss_step
  import pbss_pkg::*;
#(
  parameter int TIMER_WIDTH = TimerWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_en_i,
  input  pbss_tick_t   tick_i,
  input  pbss_cfg_t    cfg_i,
  output pbss_result_t result_o
);

  localparam int TW = TIMER_WIDTH;
  localparam int SW = TW + 1;
  localparam int CW = (TW > StepWidth) ? TW : StepWidth;
  localparam logic [TW-1:0] HoldMediumT = TW'(HoldMedium);
  localparam logic [TW-1:0] HoldFastT   = TW'(HoldFast);
  localparam logic [TW-1:0] HoldTestT   = TW'(HoldTest);

  logic            b1_prev_q, b1_prev_d, b2_prev_q, b2_prev_d;
  logic [TW-1:0]   held_q, held_d;
  logic [1:0]      beep_q, beep_d;
  logic [2:0]      blink_mode_q, blink_mode_d;
  logic            phase_q, phase_d;
  logic            buzz_blink_q, buzz_blink_d;
  logic [TW-1:0]   blink_el_q, blink_el_d;
  logic            ident_q, ident_d;
  logic [IdentWidth-1:0] ident_el_q, ident_el_d;
  logic [3:0]      test_step_q, test_step_d;
  logic [TW-1:0]   test_el_q, test_el_d;
  pbss_ovr_t       ovr_q, ovr_d;
  logic [2:0]      ana_q, ana_d;

  function automatic logic [TW-1:0] sat_add(logic [TW-1:0] a, logic [TickWidth-1:0] b);
    logic [SW-1:0] s;
    s = {1'b0, a} + SW'(b);
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  function automatic pbss_ovr_t force_bit(pbss_ovr_t o, logic [3:0] idx, logic level);
    logic [NumOverrides-1:0] m;
    pbss_ovr_t r;
    m    = NumOverrides'(1) << idx;
    r    = o;
    r.en = o.en | m;
    r.lv = level ? (o.lv | m) : (o.lv & ~m);
    return r;
  endfunction

  function automatic pbss_ovr_t release_bit(pbss_ovr_t o, logic [3:0] idx);
    logic [NumOverrides-1:0] m;
    pbss_ovr_t r;
    m    = NumOverrides'(1) << idx;
    r.en = o.en & ~m;
    r.lv = o.lv & ~m;
    return r;
  endfunction

  function automatic pbss_ovr_t keep_buzzer(pbss_ovr_t o);
    pbss_ovr_t r;
    r.en = o.en & BuzzMask;
    r.lv = o.lv & BuzzMask;
    return r;
  endfunction

  always_comb begin
    logic rose1, rose2, fell2;
    logic [IdentWidth:0] id_sum;
    logic [TickWidth-1:0] dt;

    dt    = cfg_i.tick_period_ms;
    rose1 = tick_i.button_one_level && !b1_prev_q;
    rose2 = tick_i.button_two_level && !b2_prev_q;
    fell2 = !tick_i.button_two_level && b2_prev_q;

    blink_mode_d = blink_mode_q;
    phase_d      = phase_q;
    buzz_blink_d = buzz_blink_q;
    ident_d      = ident_q;
    ident_el_d   = ident_el_q;
    test_step_d  = test_step_q;
    test_el_d    = test_el_q;
    ovr_d        = ovr_q;
    ana_d        = ana_q;
    beep_d       = beep_q;

    // advance time
    held_d     = (tick_i.button_two_level && b2_prev_q) ? sat_add(held_q, dt) : '0;
    blink_el_d = sat_add(blink_el_q, dt);
    if (test_step_q != 4'd0) begin
      test_el_d = sat_add(test_el_q, dt);
    end
    id_sum = {1'b0, ident_el_q} + (IdentWidth + 1)'(dt);
    if (ident_q) begin
      ident_el_d = id_sum[IdentWidth] ? IdentMax : id_sum[IdentWidth-1:0];
    end
    if (tick_i.identify_request) begin
      ident_d      = 1'b1;
      ident_el_d   = '0;
      buzz_blink_d = 1'b1;
    end

    // short beep
    if (beep_q != 2'd0) begin
      beep_d = beep_q - 2'd1;
      if (beep_d == 2'd0) begin
        ovr_d = release_bit(ovr_d, BitBuzz);
        ovr_d = release_bit(ovr_d, 4'd0);
        ovr_d = release_bit(ovr_d, 4'd1);
      end
    end
    if (rose1) begin
      beep_d = 2'd2;
      ovr_d  = force_bit(ovr_d, BitBuzz, 1'b1);
      ovr_d  = force_bit(ovr_d, 4'd0, !tick_i.alarm_led_one_now);
    end
    if (rose2) begin
      if (test_step_d != 4'd0) begin
        test_step_d = 4'd0;
        ovr_d       = keep_buzzer(ovr_d);
        ana_d       = 3'd0;
      end
      beep_d       = 2'd2;
      ovr_d        = force_bit(ovr_d, BitBuzz, 1'b1);
      ovr_d        = force_bit(ovr_d, 4'd1, !tick_i.alarm_led_two_now);
      blink_el_d   = '0;
      blink_mode_d = BlinkSlow;
    end

    // identify
    if (ident_d) begin
      blink_mode_d = BlinkMedium;
      if (ident_el_d > IdentLength) begin
        phase_d      = 1'b0;
        blink_mode_d = BlinkOff;
        buzz_blink_d = 1'b0;
        ovr_d        = keep_buzzer(ovr_d);
        ana_d        = 3'd0;
        ident_d      = 1'b0;
      end
    end

    // long press
    if (tick_i.button_two_level && blink_mode_d != BlinkOff) begin
      if (held_d < HoldMediumT) begin
        blink_mode_d = BlinkSlow;
      end else if (held_d < HoldFastT) begin
        blink_mode_d = BlinkMedium;
      end else if (held_d < HoldTestT) begin
        blink_mode_d = BlinkFast;
      end else begin
        phase_d      = 1'b0;
        blink_mode_d = BlinkOff;
        buzz_blink_d = 1'b0;
        ovr_d        = keep_buzzer(ovr_d);
        ana_d        = 3'd0;
        test_step_d  = 4'd1;
        test_el_d    = '0;
        ovr_d        = force_bit(ovr_d, 4'd0, 1'b1);
        ovr_d        = force_bit(ovr_d, 4'd5, 1'b1);
        ovr_d        = force_bit(ovr_d, 4'd1, 1'b0);
        ovr_d        = force_bit(ovr_d, 4'd6, 1'b0);
        ovr_d        = force_bit(ovr_d, 4'd2, 1'b0);
        ovr_d        = force_bit(ovr_d, 4'd7, 1'b0);
        ovr_d        = force_bit(ovr_d, 4'd3, 1'b0);
        ovr_d        = force_bit(ovr_d, 4'd8, 1'b0);
      end
    end
    if (fell2 && blink_mode_d != BlinkOff) begin
      phase_d      = 1'b0;
      blink_mode_d = BlinkOff;
      buzz_blink_d = 1'b0;
      ovr_d        = keep_buzzer(ovr_d);
      ana_d        = 3'd0;
    end

    // blink toggle
    if (blink_mode_d != BlinkOff) begin
      if (blink_el_d >= TW'(toggle_period_ms(blink_mode_d))) begin
        blink_el_d = '0;
        phase_d    = !phase_d;
        ovr_d      = force_bit(ovr_d, 4'd0, phase_d);
        ovr_d      = force_bit(ovr_d, 4'd1, phase_d);
        ovr_d      = force_bit(ovr_d, 4'd2, phase_d);
        ovr_d      = force_bit(ovr_d, 4'd3, phase_d);
        if (buzz_blink_d) begin
          ovr_d = force_bit(ovr_d, BitBuzz, phase_d);
        end
      end
    end

    // self-test sequence
    if (test_step_d != 4'd0 && CW'(test_el_d) >= CW'(cfg_i.relay_step_ms)) begin
      test_step_d = test_step_d + 4'd1;
      test_el_d   = '0;
      case (test_step_d) inside
        [4'd2:4'd4]: begin
          ovr_d = force_bit(ovr_d, test_step_d - 4'd2, 1'b0);
          ovr_d = force_bit(ovr_d, test_step_d + 4'd3, 1'b0);
          ovr_d = force_bit(ovr_d, test_step_d - 4'd1, 1'b1);
          ovr_d = force_bit(ovr_d, test_step_d + 4'd4, 1'b1);
        end
        4'd5: begin
          ovr_d = force_bit(ovr_d, 4'd3, 1'b0);
          ovr_d = force_bit(ovr_d, 4'd8, 1'b0);
          ovr_d = force_bit(ovr_d, 4'd4, 1'b1);
          ovr_d = force_bit(ovr_d, BitAna, 1'b0);
          ana_d = 3'd0;
        end
        4'd6: begin
          ovr_d = force_bit(ovr_d, 4'd4, 1'b0);
          ovr_d = force_bit(ovr_d, 4'd0, 1'b1);
          ovr_d = force_bit(ovr_d, BitAna, 1'b0);
          ana_d = 3'd1;
        end
        [4'd7:4'd9]: begin
          ovr_d = force_bit(ovr_d, test_step_d - 4'd6, 1'b1);
          ovr_d = force_bit(ovr_d, BitAna, 1'b0);
          ana_d = 3'(test_step_d - 4'd5);
        end
        default: begin
          if (test_step_d != 4'd0) begin
            test_step_d = 4'd0;
            ovr_d       = keep_buzzer(ovr_d);
            ana_d       = 3'd0;
          end
        end
      endcase
    end

    b1_prev_d = tick_i.button_one_level;
    b2_prev_d = tick_i.button_two_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_prev_q    <= 1'b0;
      b2_prev_q    <= 1'b0;
      held_q       <= '0;
      beep_q       <= '0;
      blink_mode_q <= BlinkOff;
      phase_q      <= 1'b0;
      buzz_blink_q <= 1'b0;
      blink_el_q   <= '0;
      ident_q      <= 1'b0;
      ident_el_q   <= '0;
      test_step_q  <= '0;
      test_el_q    <= '0;
      ovr_q        <= '0;
      ana_q        <= '0;
    end else if (step_en_i) begin
      b1_prev_q    <= b1_prev_d;
      b2_prev_q    <= b2_prev_d;
      held_q       <= held_d;
      beep_q       <= beep_d;
      blink_mode_q <= blink_mode_d;
      phase_q      <= phase_d;
      buzz_blink_q <= buzz_blink_d;
      blink_el_q   <= blink_el_d;
      ident_q      <= ident_d;
      ident_el_q   <= ident_el_d;
      test_step_q  <= test_step_d;
      test_el_q    <= test_el_d;
      ovr_q        <= ovr_d;
      ana_q        <= ana_d;
    end
  end

  // result of this item, from the updated state
  always_comb begin
    logic [NumOverrides-1:0] lv;
    lv = ovr_d.lv & ovr_d.en;
    result_o.led_override_enable    = ovr_d.en[4:0];
    result_o.led_override_level     = lv[4:0];
    result_o.relay_override_enable  = ovr_d.en[8:5];
    result_o.relay_override_level   = lv[8:5];
    result_o.buzzer_override_enable = ovr_d.en[BitBuzz];
    result_o.buzzer_override_level  = lv[BitBuzz];
    result_o.analog_override_enable = ovr_d.en[BitAna];
    result_o.analog_level_code      = ovr_d.en[BitAna] ? ana_d : 3'd0;
    result_o.blink_speed            = blink_mode_d;
    result_o.self_test_step         = test_step_d;
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_step_q <= 4'd9)
    else $error("self-test step out of range");

  a_blink_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_mode_q == BlinkOff || blink_mode_q == BlinkSlow ||
    blink_mode_q == BlinkMedium || blink_mode_q == BlinkFast)
    else $error("illegal blink mode");

  a_analog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ana_q <= 3'd4)
    else $error("analog code out of range");

  a_press_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && tick_i.button_two_level && !b2_prev_q |=>
      test_step_q == 4'd0 && beep_q == 2'd2)
    else $error("button two press did not stop the self-test and beep");

endmodule

FILE: rtl/panel_button_selftest_sequencer.sv
`timescale 1ns / 1ps
// Panel button and self-test sequencer, top level.
// Depends on pbss_pkg, pbss_apb and pbss_step.
//
// Each item on the slave stream is one poll tick: button levels, identify
// request and present alarm LED levels. For every tick the block returns
// exactly one item on the master stream carrying LED, relay, buzzer and
// analog override enables and levels, the blink speed and the self-test step.
// An accepted tick lands in an input register; when the output register is
// free or being taken, it is evaluated and written, with the state update,
// into the output register, which drives tvalid on the master side.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result holds and the input register still
// takes one more item; further items wait with s_axis_tready low.
// Reset clears the step state and valid flags and loads tick_period_ms = 50 and
// relay_step_ms = 1000. The user must write the APB port (tick period at byte
// address 0, step dwell at 4) only while the block is idle; it is not enforced.
module panel_button_selftest_sequencer
  import pbss_pkg::*;
#(
  parameter int TIMER_WIDTH = TimerWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] button_one_level, [1] button_two_level, [2] identify_request,
  // [3] alarm_led_one_now, [4] alarm_led_two_now, [7:5] zero
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] led_override_enable, [9:5] led_override_level,
  // [13:10] relay_override_enable, [17:14] relay_override_level,
  // [18] buzzer_override_enable, [19] buzzer_override_level,
  // [20] analog_override_enable, [23:21] analog_level_code,
  // [26:24] blink_speed, [30:27] self_test_step, [31] zero
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pbss_cfg_t    cfg;
  pbss_tick_t   tick_q;
  pbss_result_t result, result_q;
  logic         in_valid_q, in_valid_d;
  logic         out_valid_q, out_valid_d;
  logic         advance, s_accept;

  pbss_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      tick_q <= pbss_tick_t'(s_axis_tdata[4:0]);
    end
    if (advance) begin
      result_q <= result;
    end
  end

  pbss_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .tick_i    (tick_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for panel_button_selftest_sequencer: directed and random poll ticks,
// APB register changes between phases, and an override predictor checking each result.
// Depends on pbss_pkg and the RTL of the block.
module tb;
  import pbss_pkg::*;

  localparam int unsigned TimerMax   = 65535;
  localparam int unsigned IdentSat   = 4095;
  localparam int unsigned IdentEnd   = 2000;
  localparam int unsigned BlinkBase  = 250;
  localparam int unsigned CycleLimit = 400000;
  localparam int          NumPhases  = 8;
  localparam int          PhaseItems = 80;
  localparam int          NumDirected = 20;

  // {led2, led1, identify, button two, button one}, first item at the top
  localparam logic [5*NumDirected-1:0] DirectedTicks = {
    5'b00000, 5'b11111, 5'b11111, 5'b11000, 5'b00001,
    5'b01001, 5'b00000, 5'b10010, 5'b00010, 5'b00010,
    5'b00000, 5'b00100, 5'b00000, 5'b00000, 5'b00011,
    5'b00111, 5'b00000, 5'b01010, 5'b00000, 5'b10000
  };
  localparam logic [10*NumPhases-1:0] PhaseTicks = {
    10'd50, 10'd1000, 10'd250, 10'd1023, 10'd0, 10'd100, 10'd1, 10'd300
  };
  localparam logic [16*NumPhases-1:0] PhaseSteps = {
    16'd1000, 16'd50, 16'd0, 16'd65535, 16'd60000, 16'd200, 16'd50, 16'd1500
  };

  class override_predictor;
    bit [9:0]       tick_ms = TickPeriodReset;
    bit [15:0]      step_ms = RelayStepReset;
    bit             b1_prev, b2_prev;
    int unsigned    held_ms, blink_ms, test_ms, ident_ms;
    int unsigned    beep_left;
    bit [2:0]       mode;
    bit             phase, buzz_blink, ident_on;
    bit [3:0]       test_step;
    bit [10:0]      ovr_en, ovr_lv;
    bit [2:0]       ana_code;
    pbss_result_t   expected_outputs[$];
    int             mismatches;

    function int unsigned sat(int unsigned a, int unsigned b, int unsigned m);
      return (a + b > m) ? m : a + b;
    endfunction

    function void set_ovr(int b, bit level);
      ovr_en[b] = 1'b1;
      ovr_lv[b] = level;
    endfunction

    function void clr_ovr(int b);
      ovr_en[b] = 1'b0;
      ovr_lv[b] = 1'b0;
    endfunction

    function void set_analog(int code);
      set_ovr(BitAna, 1'b0);
      ana_code = 3'(code);
    endfunction

    function void clear_all_but_buzzer();
      for (int b = 0; b < 9; b++) clr_ovr(b);
      clr_ovr(BitAna);
      ana_code = 0;
    endfunction

    function void stop_blink();
      phase = 0;
      mode = BlinkOff;
      buzz_blink = 0;
      clear_all_but_buzzer();
    endfunction

    function void stop_test();
      if (test_step == 0) return;
      test_step = 0;
      clear_all_but_buzzer();
    endfunction

    function void begin_test();
      test_step = 1;
      test_ms = 0;
      set_ovr(0, 1'b1);
      set_ovr(5, 1'b1);
      for (int i = 1; i < 4; i++) begin
        set_ovr(i, 1'b0);
        set_ovr(5 + i, 1'b0);
      end
    endfunction

    function void advance_test();
      int s;
      if (test_step == 0) return;
      if (test_ms < step_ms) return;
      test_step = test_step + 4'd1;
      test_ms = 0;
      s = int'(test_step);
      case (s)
        2, 3, 4: begin
          set_ovr(s - 2, 1'b0);
          set_ovr(s + 3, 1'b0);
          set_ovr(s - 1, 1'b1);
          set_ovr(s + 4, 1'b1);
        end
        5: begin
          set_ovr(3, 1'b0);
          set_ovr(8, 1'b0);
          set_ovr(4, 1'b1);
          set_analog(0);
        end
        6: begin
          set_ovr(4, 1'b0);
          set_ovr(0, 1'b1);
          set_analog(1);
        end
        7, 8, 9: begin
          set_ovr(s - 6, 1'b1);
          set_analog(s - 5);
        end
        default: stop_test();
      endcase
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr[2] == RegTickPeriod) tick_ms = data[9:0];
      else step_ms = data[15:0];
    endfunction

    function void note_tick(pbss_tick_t t);
      bit           rose1, rose2, fell2;
      int unsigned  dt, interval;
      bit [10:0]    lv;
      pbss_result_t r;
      dt = int'(tick_ms);
      rose1 = t.button_one_level && !b1_prev;
      rose2 = t.button_two_level && !b2_prev;
      fell2 = !t.button_two_level && b2_prev;

      held_ms = (t.button_two_level && b2_prev) ? sat(held_ms, dt, TimerMax) : 0;
      blink_ms = sat(blink_ms, dt, TimerMax);
      if (test_step != 0) test_ms = sat(test_ms, dt, TimerMax);
      if (ident_on) ident_ms = sat(ident_ms, dt, IdentSat);
      if (t.identify_request) begin
        ident_on = 1;
        ident_ms = 0;
        buzz_blink = 1;
      end

      if (beep_left > 0) begin
        beep_left--;
        if (beep_left == 0) begin
          clr_ovr(BitBuzz);
          clr_ovr(0);
          clr_ovr(1);
        end
      end
      if (rose1) begin
        beep_left = 2;
        set_ovr(BitBuzz, 1'b1);
        set_ovr(0, !t.alarm_led_one_now);
      end
      if (rose2) begin
        stop_test();
        beep_left = 2;
        set_ovr(BitBuzz, 1'b1);
        set_ovr(1, !t.alarm_led_two_now);
        blink_ms = 0;
        mode = BlinkSlow;
      end

      if (ident_on) begin
        mode = BlinkMedium;
        if (ident_ms > IdentEnd) begin
          stop_blink();
          ident_on = 0;
        end
      end

      if (t.button_two_level && mode != BlinkOff) begin
        if (held_ms < HoldMedium) mode = BlinkSlow;
        else if (held_ms < HoldFast) mode = BlinkMedium;
        else if (held_ms < HoldTest) mode = BlinkFast;
        else begin
          stop_blink();
          begin_test();
        end
      end
      if (fell2 && mode != BlinkOff) stop_blink();
      if (mode != BlinkOff) begin
        interval = BlinkBase / mode;
        if (blink_ms >= interval) begin
          blink_ms = 0;
          phase = !phase;
          for (int i = 0; i < 4; i++) set_ovr(i, phase);
          if (buzz_blink) set_ovr(BitBuzz, phase);
        end
      end

      advance_test();
      b1_prev = t.button_one_level;
      b2_prev = t.button_two_level;

      lv = ovr_lv & ovr_en;
      r.led_override_enable    = ovr_en[4:0];
      r.led_override_level     = lv[4:0];
      r.relay_override_enable  = ovr_en[8:5];
      r.relay_override_level   = lv[8:5];
      r.buzzer_override_enable = ovr_en[BitBuzz];
      r.buzzer_override_level  = lv[BitBuzz];
      r.analog_override_enable = ovr_en[BitAna];
      r.analog_level_code      = ovr_en[BitAna] ? ana_code : 3'd0;
      r.blink_speed            = mode;
      r.self_test_step         = test_step;
      expected_outputs.push_back(r);
    endfunction

    function int cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_outputs(logic [31:0] d);
      pbss_result_t e, a;
      if (expected_outputs.size() == 0) begin
        $error("result with no tick pending: %h", d);
        mismatches++;
        return;
      end
      e = expected_outputs.pop_front();
      a = d[30:0];
      mismatches += cmp("led_override_enable", e.led_override_enable, a.led_override_enable);
      mismatches += cmp("led_override_level", e.led_override_level, a.led_override_level);
      mismatches += cmp("relay_override_enable", e.relay_override_enable,
                        a.relay_override_enable);
      mismatches += cmp("relay_override_level", e.relay_override_level,
                        a.relay_override_level);
      mismatches += cmp("buzzer_override_enable", e.buzzer_override_enable,
                        a.buzzer_override_enable);
      mismatches += cmp("buzzer_override_level", e.buzzer_override_level,
                        a.buzzer_override_level);
      mismatches += cmp("analog_override_enable", e.analog_override_enable,
                        a.analog_override_enable);
      mismatches += cmp("analog_level_code", e.analog_level_code, a.analog_level_code);
      mismatches += cmp("blink_speed", e.blink_speed, a.blink_speed);
      mismatches += cmp("self_test_step", e.self_test_step, a.self_test_step);
      mismatches += cmp("reserved", 32'd0, d[31]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  override_predictor pred = new;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int items_left;
  int unsigned cycles = 0;

  panel_button_selftest_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) pred.write_reg(paddr, pwdata);
      if (m_axis_tvalid && m_axis_tready) pred.check_outputs(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) pred.note_tick(s_axis_tdata[4:0]);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit coin(int odds);
    return odds != 0 && $urandom_range(1, odds) == 1;
  endfunction

  task automatic send_tick(input pbss_tick_t t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // each button and identify field set with odds 1 in n, 0 never
  task automatic send_run(input int n, input int b1_odds, input int b2_odds,
                          input int id_odds);
    pbss_tick_t t;
    repeat (n) begin
      if (items_left > 0) begin
        t.button_one_level  = coin(b1_odds);
        t.button_two_level  = coin(b2_odds);
        t.identify_request  = coin(id_odds);
        t.alarm_led_one_now = $urandom_range(0, 1);
        t.alarm_led_two_now = $urandom_range(0, 1);
        send_tick(t);
        items_left--;
      end
    end
  endtask

  task automatic play_random(input int budget, input int unsigned tick);
    int span, ident_span, kind;
    span = (tick == 0) ? 12 : 7000 / tick + 3;
    if (span > 70) span = 70;
    ident_span = (tick == 0) ? 5 : 2000 / tick + 3;
    if (ident_span > 40) ident_span = 40;
    items_left = budget;
    while (items_left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        send_run($urandom_range(1, span), 4, 1, 20);
        send_run($urandom_range(1, 3), 4, 0, 20);
      end else if (kind < 7) begin
        send_run($urandom_range(1, 4), 1, 0, 0);
        send_run($urandom_range(1, 2), 0, 0, 0);
      end else if (kind == 7) begin
        send_run(1, 0, 0, 1);
        send_run($urandom_range(1, ident_span), 0, 0, 0);
      end else if (kind == 8) begin
        send_run($urandom_range(1, 40), 0, 0, 0);
      end else begin
        send_run($urandom_range(1, 5), 2, 2, 2);
      end
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pred.expected_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [9:0] tick, input logic [15:0] step);
    for (int r = 0; r < 2; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (r == 0) ? {RegTickPeriod, 2'b00} : {RegRelayStep, 2'b00};
      pwdata  <= (r == 0) ? 32'(tick) : 32'(step);
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      send_tick(DirectedTicks[5*(NumDirected-1-i) +: 5]);
    end

    for (int p = 0; p < NumPhases; p++) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clk_i);
      if (p > 0) write_config(PhaseTicks[10*(NumPhases-1-p) +: 10],
                              PhaseSteps[16*(NumPhases-1-p) +: 16]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      play_random(PhaseItems, PhaseTicks[10*(NumPhases-1-p) +: 10]);
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pred.mismatches == 0 && pred.expected_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pbss_pkg.sv
rtl/pbss_apb.sv
rtl/pbss_step.sv
rtl/panel_button_selftest_sequencer.sv
verif/tb.sv
